// ===== design/zsdu_pkg.sv =====
package zsdu_pkg;

    // input item modes
    typedef enum logic [1:0] {
        MODE_RESTART  = 2'd0,
        MODE_PASSWORD = 2'd1,
        MODE_CIPHER   = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LD1,
        S_LD2,
        S_X,
        S_K1,
        S_K2,
        S_K3
    } t_state;

    // state memory layout, one word per entry
    typedef enum logic [1:0] {
        ADDR_K1  = 2'd0,
        ADDR_K2  = 2'd1,
        ADDR_K3  = 2'd2,
        ADDR_CHK = 2'd3
    } t_addr;

    localparam int unsigned MEM_DEPTH = 4;
    localparam int unsigned WORD_W    = 32;

    // utf-8 checker state as stored in the checker entry
    typedef struct packed {
        logic [1:0] pending;
        logic       invalid;
    } t_chk;

    localparam int unsigned CHK_W = $bits(t_chk);

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] LCG_MUL     = 32'd134775813;
    localparam logic [31:0] INIT_FIRST  = 32'd305419896;
    localparam logic [31:0] INIT_SECOND = 32'd591751049;
    localparam logic [31:0] INIT_THIRD  = 32'd878082192;

    // crc-32 table entry, reflected polynomial
    function automatic logic [31:0] crc_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = CRC_POLY ^ (v >> 1);
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    // value of an entry that has not been written since restart
    function automatic logic [31:0] init_value(input t_addr addr);
        logic [31:0] v;
        case (addr)
            ADDR_K1:  v = INIT_FIRST;
            ADDR_K2:  v = INIT_SECOND;
            ADDR_K3:  v = INIT_THIRD;
            default:  v = '0;
        endcase
        return v;
    endfunction

    // one plaintext byte through the utf-8 checker
    function automatic t_chk utf8_next(input t_chk cur, input logic [7:0] x);
        t_chk nxt;
        nxt = cur;
        if (cur.pending != 2'd0) begin
            if (x[7:6] != 2'b10) begin
                nxt.invalid = 1'b1;
            end
            nxt.pending = cur.pending - 2'd1;
        end else if (x[7]) begin
            if (x[7:5] == 3'b110) begin
                nxt.pending = 2'd1;
            end else if (x[7:4] == 4'b1110) begin
                nxt.pending = 2'd2;
            end else begin
                nxt.invalid = 1'b1;
                nxt.pending = 2'd0;
            end
        end
        return nxt;
    endfunction

endpackage

// ===== design/zip_stream_decrypt_utf8_check.sv =====
// PKZIP traditional stream decryptor with a UTF-8 plausibility check.
// Input channel (i_valid / o_ready) takes one item: i_mode and i_data_byte.
//   restart: loads the initial keys and clears the checker.
//   password byte: advances the keys, no result.
//   cipher byte: one result (o_plain_byte, o_text_ok) on the output
//   channel (o_valid / i_ready); the next item is taken only back in idle.
//   unused mode: accepted and dropped.
// The keys and the checker state sit in a 4-word state memory with two
// registered read ports and one write port; the item sequence reads the words
// it needs, then writes back the checker word (cipher bytes only), key_first,
// key_second and key_third in separate cycles, which sets the rate. The result
// is loaded into the output register at the result step, after the load steps
// S_LD1 and S_LD2. A held result waits there while the block goes on; the next
// cipher byte stalls at its result step until the receiver takes the previous one.
// Reset (synchronous, active low) clears the per-word valid bits, so every
// word reads as its initial value; a restart item does the same.
module zip_stream_decrypt_utf8_check
    import zsdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_plain_byte,
    output logic       o_text_ok
);

    // state memory and per-word valid bits
    logic [WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;

    logic [WORD_W-1:0] r_rd_a_raw;
    logic [WORD_W-1:0] r_rd_b_raw;
    logic              r_rd_a_vld;
    logic              r_rd_b_vld;
    t_addr             r_rd_a_addr;
    t_addr             r_rd_b_addr;
    logic [WORD_W-1:0] rd_a_val;
    logic [WORD_W-1:0] rd_b_val;

    t_state r_state;
    t_state n_state;

    t_addr             rd_a;
    t_addr             rd_b;
    logic              wr_en;
    t_addr             wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              out_load;
    logic              clear_valid;
    logic              in_acc;

    // datapath registers
    t_mode       r_mode;
    logic [7:0]  r_data;
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [31:0] r_k3;
    t_chk        r_chk;
    logic [7:0]  r_ks;
    logic [7:0]  r_x;

    logic        r_out_valid;
    logic [7:0]  r_plain;
    logic        r_ok;

    logic [15:0] ks_t;
    logic [31:0] ks_prod;
    logic [7:0]  x_cipher;
    t_chk        chk_next;
    logic [31:0] n_k1;
    logic [31:0] n_k2;
    logic [31:0] n_k3;

    assign in_acc       = i_valid && o_ready;
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_plain_byte = r_plain;
    assign o_text_ok    = r_ok;

    // unwritten words read as their initial values
    assign rd_a_val = r_rd_a_vld ? r_rd_a_raw : init_value(r_rd_a_addr);
    assign rd_b_val = r_rd_b_vld ? r_rd_b_raw : init_value(r_rd_b_addr);

    // key arithmetic
    assign ks_t     = r_k3[15:0] | 16'd2;
    assign ks_prod  = {16'd0, ks_t} * {16'd0, ks_t ^ 16'd1};
    assign x_cipher = r_data ^ r_ks;
    assign chk_next = utf8_next(r_chk, x_cipher);
    assign n_k1     = crc_entry(r_k1[7:0] ^ r_x) ^ {8'd0, r_k1[31:8]};
    assign n_k2     = 32'(r_k2 * LCG_MUL) + 32'd1;
    assign n_k3     = crc_entry(r_k3[7:0] ^ r_k2[31:24]) ^ {8'd0, r_k3[31:8]};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, memory ports and strobes
    always_comb begin
        n_state     = r_state;
        rd_a        = ADDR_K3;
        rd_b        = ADDR_K1;
        wr_en       = 1'b0;
        wr_addr     = ADDR_K1;
        wr_data     = '0;
        out_load    = 1'b0;
        clear_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_RESTART:  clear_valid = 1'b1;
                        MODE_PASSWORD: n_state = S_LD1;
                        MODE_CIPHER:   n_state = S_LD1;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_LD1: begin
                rd_a    = ADDR_K2;
                rd_b    = ADDR_CHK;
                n_state = S_LD2;
            end
            S_LD2: begin
                n_state = (r_mode == MODE_CIPHER) ? S_X : S_K1;
            end
            S_X: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = ADDR_CHK;
                    wr_data  = {{(WORD_W - CHK_W){1'b0}}, chk_next};
                    n_state  = S_K1;
                end
            end
            S_K1: begin
                wr_en   = 1'b1;
                wr_addr = ADDR_K1;
                wr_data = n_k1;
                n_state = S_K2;
            end
            S_K2: begin
                wr_en   = 1'b1;
                wr_addr = ADDR_K2;
                wr_data = n_k2;
                n_state = S_K3;
            end
            S_K3: begin
                wr_en   = 1'b1;
                wr_addr = ADDR_K3;
                wr_data = n_k3;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory write and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a_raw  <= r_mem[rd_a];
        r_rd_b_raw  <= r_mem[rd_b];
        r_rd_a_addr <= rd_a;
        r_rd_b_addr <= rd_b;
    end

    // valid bits, read alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            r_rd_a_vld <= r_valid[rd_a];
            r_rd_b_vld <= r_valid[rd_b];
            if (clear_valid) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= t_mode'(i_mode);
            r_data <= i_data_byte;
        end
        case (r_state)
            S_LD1: begin
                r_k3 <= rd_a_val;
                r_k1 <= rd_b_val;
            end
            S_LD2: begin
                r_k2  <= rd_a_val;
                r_chk <= t_chk'(rd_b_val[CHK_W-1:0]);
                r_ks  <= ks_prod[15:8];
                r_x   <= r_data;
            end
            S_X: begin
                if (out_load) begin
                    r_x <= x_cipher;
                end
            end
            S_K1: begin
                r_k1 <= n_k1;
                r_k2 <= r_k2 + {24'd0, n_k1[7:0]};
            end
            S_K2: begin
                r_k2 <= n_k2;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_plain <= x_cipher;
            r_ok    <= !chk_next.invalid;
        end
    end

`ifndef SYNTHESIS
    // a result only appears from the result step
    a_out_from_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_X))
        else $error("result raised outside the result step");

    // a held result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_ready))
        else $error("result loaded over an untaken one");

    // the flag stays down once the checker saw an error
    a_sticky_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_chk.invalid) |=> !r_ok)
        else $error("text flag rose after an error");

    // no write back while the block waits for an item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("memory write while idle");

    // restart leaves every word at its initial value
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_RESTART) |=> (r_valid == '0))
        else $error("restart did not clear the valid bits");
`endif

endmodule

// ===== tb/tb_zip_stream_decrypt_utf8_check.sv =====
module tb_zip_stream_decrypt_utf8_check
    import zsdu_pkg::*;
;

    localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [31:0] LCG_FACTOR     = 32'd134775813;
    localparam logic [31:0] SEED_ONE       = 32'h1234_5678;
    localparam logic [31:0] SEED_TWO       = 32'h2345_6789;
    localparam logic [31:0] SEED_THREE     = 32'h3456_7890;
    localparam int unsigned RANDOM_ITEMS   = 1300;

    // one decrypted byte as the block should report it
    typedef struct packed {
        logic [7:0] plain;
        logic       ok;
    } t_plain_result;

    // tracks key state and utf-8 state, holds the plaintext still due
    class decrypt_scoreboard;
        logic [31:0]   key_one;
        logic [31:0]   key_two;
        logic [31:0]   key_three;
        logic [1:0]    utf_pending;
        logic          utf_bad;
        t_plain_result plain_due[$];
        int unsigned   errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            key_one     = SEED_ONE;
            key_two     = SEED_TWO;
            key_three   = SEED_THREE;
            utf_pending = 2'd0;
            utf_bad     = 1'b0;
        endfunction

        // bitwise reflected crc-32 update by one byte
        function logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ POLY_REFLECTED) : (c >> 1);
            end
            return c;
        endfunction

        function void absorb(input logic [7:0] b);
            key_one   = crc_update(key_one, b);
            key_two   = (key_two + {24'd0, key_one[7:0]}) * LCG_FACTOR + 32'd1;
            key_three = crc_update(key_three, key_two[31:24]);
        endfunction

        function logic [7:0] keystream();
            logic [31:0] t;
            logic [31:0] prod;
            t    = {16'd0, key_three[15:0] | 16'h0002};
            prod = t * (t ^ 32'd1);
            return prod[15:8];
        endfunction

        // utf-8 rules for characters of at most three bytes
        function void utf8_step(input logic [7:0] x);
            if (utf_pending != 2'd0) begin
                if (x[7:6] != 2'b10) begin
                    utf_bad = 1'b1;
                end
                utf_pending = utf_pending - 2'd1;
            end else begin
                casez (x)
                    8'b0???????: ;
                    8'b110?????: utf_pending = 2'd1;
                    8'b1110????: utf_pending = 2'd2;
                    default: begin
                        utf_bad     = 1'b1;
                        utf_pending = 2'd0;
                    end
                endcase
            end
        endfunction

        // accepted input transaction
        function void note_item(input t_mode m, input logic [7:0] d);
            t_plain_result r;
            case (m)
                MODE_RESTART:  restart();
                MODE_PASSWORD: absorb(d);
                MODE_CIPHER: begin
                    r.plain = d ^ keystream();
                    utf8_step(r.plain);
                    absorb(r.plain);
                    r.ok = !utf_bad;
                    plain_due.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // accepted output transaction
        function void check_result(input logic [7:0] plain, input logic ok);
            t_plain_result e;
            if (plain_due.size() == 0) begin
                $display("%0t unexpected result: plain_byte %02h text_ok %0b", $time, plain, ok);
                errors++;
            end else begin
                e = plain_due.pop_front();
                if (plain !== e.plain) begin
                    $display("%0t plain_byte mismatch: expected %02h, actual %02h",
                             $time, e.plain, plain);
                    errors++;
                end
                if (ok !== e.ok) begin
                    $display("%0t text_ok mismatch: expected %0b, actual %0b",
                             $time, e.ok, ok);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_mode;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_plain_byte;
    logic       o_text_ok;

    decrypt_scoreboard sb = new();
    int unsigned items_sent;
    int unsigned burst_left;

    zip_stream_decrypt_utf8_check uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_plain_byte (o_plain_byte),
        .o_text_ok    (o_text_ok)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // one input transaction, sender may idle between bursts
    task automatic send_item(input t_mode m, input logic [7:0] d);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_data_byte <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(m, d);
        if (m != MODE_UNUSED) begin
            items_sent++;
        end
    endtask

    // cipher byte that decrypts to the given plaintext
    task automatic send_plain(input logic [7:0] p);
        send_item(MODE_CIPHER, p ^ sb.keystream());
    endtask

    // one well-formed character of one to three bytes
    task automatic send_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send_plain(8'($urandom_range(8'h00, 8'h7F)));
        end else if (pick < 8) begin
            send_plain(8'($urandom_range(8'hC0, 8'hDF)));
            send_plain(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
            send_plain(8'($urandom_range(8'hE0, 8'hEF)));
            send_plain(8'($urandom_range(8'h80, 8'hBF)));
            send_plain(8'($urandom_range(8'h80, 8'hBF)));
        end
    endtask

    // broken text or noise
    task automatic send_broken();
        case ($urandom_range(0, 5))
            0: send_plain(8'($urandom_range(8'h80, 8'hBF)));
            1: send_plain(8'($urandom_range(8'hF0, 8'hFF)));
            2: send_plain(8'($urandom_range(8'hC0, 8'hEF)));
            3: begin
                send_plain(8'($urandom_range(8'hE0, 8'hEF)));
                send_plain(8'($urandom_range(8'h80, 8'hBF)));
            end
            4: send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
            default: send_item(MODE_CIPHER, 8'($urandom_range(0, 255)));
        endcase
    endtask

    // optional restart, password, then a run of text or raw ciphertext noise
    task automatic send_message();
        int unsigned n_pw;
        int unsigned n_chars;
        n_pw = $urandom_range(0, 12);
        if ($urandom_range(0, 7) != 0) begin
            send_item(MODE_RESTART, 8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < n_pw; i++) begin
            send_item(MODE_PASSWORD, 8'($urandom_range(0, 255)));
        end
        n_chars = $urandom_range(5, 40);
        if ($urandom_range(0, 9) == 0) begin
            // raw ciphertext noise
            for (int i = 0; i < n_chars; i++) begin
                send_item(MODE_CIPHER, 8'($urandom_range(0, 255)));
            end
        end else begin
            for (int i = 0; i < n_chars; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_broken();
                end else begin
                    send_char();
                end
            end
        end
    endtask

    // receiver with its own stall pattern, checks each output transaction
    initial begin : drain
        int unsigned phase_left;
        int unsigned style;
        phase_left = 0;
        style      = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result(o_plain_byte, o_text_ok);
            end
            if (phase_left == 0) begin
                style      = $urandom_range(0, 3);
                phase_left = $urandom_range(8, 60);
            end
            phase_left--;
            case (style)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 1);
                2: i_ready <= ($urandom_range(0, 5) == 0);
                default: i_ready <= (phase_left == 0);
            endcase
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        items_sent = 0;
        burst_left = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_mode      <= MODE_RESTART;
        i_data_byte <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and each utf-8 case
        send_item(MODE_RESTART, 8'hFF);
        send_item(MODE_PASSWORD, 8'h00);
        send_item(MODE_PASSWORD, 8'hFF);
        send_item(MODE_UNUSED, 8'hFF);
        send_plain(8'h00);
        send_plain(8'h7F);
        send_plain(8'hC3);
        send_plain(8'hA9);
        send_plain(8'hE2);
        send_plain(8'h82);
        send_plain(8'hAC);
        // unfinished character is not flagged
        send_plain(8'hE2);
        send_item(MODE_RESTART, 8'h00);
        send_plain(8'hDF);
        send_plain(8'hBF);
        // stray continuation, then the flag stays low
        send_plain(8'h80);
        send_plain(8'h41);
        // four-byte lead
        send_item(MODE_RESTART, 8'h00);
        send_plain(8'hF0);
        // missing continuation
        send_item(MODE_RESTART, 8'h00);
        send_plain(8'hC2);
        send_plain(8'h41);
        // invalid lead and raw ciphertext extremes
        send_item(MODE_RESTART, 8'h00);
        send_plain(8'hFF);
        send_item(MODE_CIPHER, 8'h00);
        send_item(MODE_CIPHER, 8'hFF);

        // random messages
        while (items_sent < RANDOM_ITEMS) begin
            send_message();
        end
        i_valid <= 1'b0;

        while (sb.plain_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.plain_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
